// ===== rtl/lgrs_pkg.sv =====
// ============================================================================
// lgrs_pkg: shared definitions for the Life generation row stepper
// Row geometry, row index limits, the result record and the column mask.
// ============================================================================
package lgrs_pkg;

    // Row geometry and frame limits.
    localparam int ROW_WIDTH   = 64;
    localparam int MAX_ROWS    = 1024;
    localparam int ROW_IDX_W   = 10;
    localparam int GRID_W_W    = 7;
    localparam logic [ROW_IDX_W-1:0] ROW_IDX_MAX = ROW_IDX_W'(MAX_ROWS - 1);
    localparam logic [GRID_W_W-1:0]  GRID_W_RESET = GRID_W_W'(ROW_WIDTH);

    // Life rule constants: birth on three, survival on two or three.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Output queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ROW_WIDTH-1:0] row_t;

    // One result row as it waits in the output queue.
    typedef struct packed {
        row_t                 cells;
        logic [ROW_IDX_W-1:0] row_index;
        logic                 frame_done;
    } result_t;

    // Write request from the stepper into the output queue.
    typedef struct packed {
        logic  [1:0] count;
        result_t     first;
        result_t     second;
    } queue_push_t;

    // Mask with one bit set for each column below the configured width.
    function automatic row_t width_mask(input logic [GRID_W_W-1:0] grid_width);
        row_t m;
        m = '0;
        for (int i = 0; i < ROW_WIDTH; i++)
        begin
            m[i] = (int'(grid_width) > i);
        end
        return m;
    endfunction

endpackage

// ===== rtl/lgrs_in_if.sv =====
// ============================================================================
// lgrs_in_if: input row channel
// Carries one grid row per transaction with a valid/ready handshake.
// ============================================================================
interface lgrs_in_if;
    logic               valid;
    logic               ready;
    lgrs_pkg::row_t     row_cells;
    logic               last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

// ===== rtl/lgrs_out_if.sv =====
// ============================================================================
// lgrs_out_if: result row channel
// Carries one next-generation row per transaction with a valid/ready handshake.
// ============================================================================
interface lgrs_out_if;
    logic                               valid;
    logic                               ready;
    lgrs_pkg::row_t                     next_cells;
    logic [lgrs_pkg::ROW_IDX_W-1:0]     out_row_index;
    logic                               frame_done;

    modport source (output valid, output next_cells, output out_row_index,
                    output frame_done, input ready);
    modport sink   (input valid, input next_cells, input out_row_index,
                    input frame_done, output ready);
endinterface

// ===== rtl/life_generation_row_stepper.sv =====
// ============================================================================
// life_generation_row_stepper: one Life generation over a streamed grid
// Takes grid rows top first and returns the next generation row by row.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one grid row per transaction (row_cells, last_row).
//   out_ch carries one next-generation row per transaction with its row
//   index (saturating at MAX_ROWS-1) and frame_done on the bottom row.
//   cfg_wr_en/cfg_wr_data write grid_width; write it only while idle.
//   Each row after the first releases the result for the row above it; a
//   row marked last_row also releases its own result, so unless it is the
//   first row it yields two. Results enter the output queue as the row
//   that releases them is accepted. Throughput: one row per cycle while
//   in_ch.ready is high. Two banks of 64 cell lanes compute both possible
//   result rows in the accept cycle; the queue drains one result per cycle
//   while out_ch.ready is high, so a bottom row's two results leave in turn.
//   Stall: results wait in a four-entry queue; in_ch.ready drops once fewer
//   than two entries are free, and rows are held off until it drains.
//   Reset: the frame restarts empty, the queue is cleared and grid_width
//   returns to 64.
// ============================================================================
module life_generation_row_stepper
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lgrs_pkg::GRID_W_W-1:0]    cfg_wr_data,
    lgrs_in_if.sink                          in_ch,
    lgrs_out_if.source                       out_ch
);

    logic [lgrs_pkg::GRID_W_W-1:0]   grid_width_reg;
    lgrs_pkg::row_t                  row_above_reg;
    lgrs_pkg::row_t                  row_above_next;
    lgrs_pkg::row_t                  row_middle_reg;
    lgrs_pkg::row_t                  row_middle_next;
    logic [lgrs_pkg::ROW_IDX_W-1:0]  rows_seen_reg;
    logic [lgrs_pkg::ROW_IDX_W-1:0]  rows_seen_next;
    logic                            middle_valid_reg;
    logic                            middle_valid_next;

    lgrs_pkg::row_t                  mask;
    lgrs_pkg::row_t                  cur_row;
    lgrs_pkg::row_t                  mid_or_dead;
    lgrs_pkg::row_t                  next_mid_row;
    lgrs_pkg::row_t                  next_cur_row;
    logic [lgrs_pkg::ROW_IDX_W-1:0]  cur_index;
    logic                            accept;
    lgrs_pkg::queue_push_t           push;
    lgrs_pkg::result_t               head;
    logic [lgrs_pkg::QUEUE_CNT_W-1:0] queue_count;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= lgrs_pkg::GRID_W_RESET;
        end
        else if (cfg_wr_en)
        begin
            grid_width_reg <= cfg_wr_data;
        end
    end

    // Input handshake: room is kept for the two results of a bottom row.
    assign in_ch.ready = (queue_count <= lgrs_pkg::QUEUE_CNT_W'(lgrs_pkg::QUEUE_DEPTH - 2));
    assign accept      = in_ch.valid && in_ch.ready;

    assign mask        = lgrs_pkg::width_mask(grid_width_reg);
    assign cur_row     = in_ch.row_cells & mask;
    assign mid_or_dead = middle_valid_reg ? row_middle_reg : '0;

    // Row index of the incoming row, saturating at the last legal index.
    always_comb
    begin
        if (!middle_valid_reg)
        begin
            cur_index = '0;
        end
        else if (rows_seen_reg == lgrs_pkg::ROW_IDX_MAX)
        begin
            cur_index = rows_seen_reg;
        end
        else
        begin
            cur_index = rows_seen_reg + lgrs_pkg::ROW_IDX_W'(1);
        end
    end

    // Lane bank for the stored middle row, with the new row below it.
    lgrs_row u_mid_row
    (
        .up   (row_above_reg),
        .mid  (row_middle_reg),
        .down (cur_row),
        .mask (mask),
        .next (next_mid_row)
    );

    // Lane bank for the new row itself, with a dead row below the grid.
    lgrs_row u_cur_row
    (
        .up   (mid_or_dead),
        .mid  (cur_row),
        .down ('0),
        .mask (mask),
        .next (next_cur_row)
    );

    // Order the results of this transaction for the queue.
    always_comb
    begin
        push.first.cells       = next_mid_row;
        push.first.row_index   = rows_seen_reg;
        push.first.frame_done  = 1'b0;
        push.second.cells      = next_cur_row;
        push.second.row_index  = cur_index;
        push.second.frame_done = 1'b1;
        push.count             = 2'd0;
        if (accept)
        begin
            if (middle_valid_reg)
            begin
                push.count = in_ch.last_row ? 2'd2 : 2'd1;
            end
            else if (in_ch.last_row)
            begin
                push.first = push.second;
                push.count = 2'd1;
            end
        end
    end

    // Row history update; the bottom row closes the frame.
    always_comb
    begin
        row_above_next    = row_above_reg;
        row_middle_next   = row_middle_reg;
        rows_seen_next    = rows_seen_reg;
        middle_valid_next = middle_valid_reg;
        if (accept)
        begin
            if (in_ch.last_row)
            begin
                row_above_next    = '0;
                row_middle_next   = '0;
                rows_seen_next    = '0;
                middle_valid_next = 1'b0;
            end
            else
            begin
                row_above_next    = mid_or_dead;
                row_middle_next   = cur_row;
                rows_seen_next    = cur_index;
                middle_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_above_reg    <= '0;
            row_middle_reg   <= '0;
            rows_seen_reg    <= '0;
            middle_valid_reg <= 1'b0;
        end
        else
        begin
            row_above_reg    <= row_above_next;
            row_middle_reg   <= row_middle_next;
            rows_seen_reg    <= rows_seen_next;
            middle_valid_reg <= middle_valid_next;
        end
    end

    // Output queue.
    lgrs_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_ch.valid && out_ch.ready),
        .head  (head),
        .count (queue_count)
    );

    assign out_ch.valid         = (queue_count != '0);
    assign out_ch.next_cells    = head.cells;
    assign out_ch.out_row_index = head.row_index;
    assign out_ch.frame_done    = head.frame_done;

endmodule

// ===== rtl/lgrs_lane.sv =====
// ============================================================================
// lgrs_lane: one cell lane
// Counts the eight neighbors of a cell and applies the B3/S23 rule.
// ============================================================================
module lgrs_lane
(
    input  logic [2:0] up,
    input  logic [2:0] mid,
    input  logic [2:0] down,
    output logic       alive
);

    logic [3:0] neighbors;

    // Sum of the eight cells around the center; the center itself is excluded.
    assign neighbors = {3'b000, up[0]}   + {3'b000, up[1]}   + {3'b000, up[2]}
                     + {3'b000, mid[0]}                      + {3'b000, mid[2]}
                     + {3'b000, down[0]} + {3'b000, down[1]} + {3'b000, down[2]};

    // Birth on three neighbors, survival of a live cell on two.
    assign alive = (neighbors == lgrs_pkg::BIRTH_COUNT)
                || ((neighbors == lgrs_pkg::SURVIVE_COUNT) && mid[1]);

endmodule

// ===== rtl/lgrs_row.sv =====
// ============================================================================
// lgrs_row: one row of cell lanes
// Runs a lane for every column in parallel and merges the lane outputs into
// the next-generation row, cleared outside the configured width.
// ============================================================================
module lgrs_row
(
    input  lgrs_pkg::row_t up,
    input  lgrs_pkg::row_t mid,
    input  lgrs_pkg::row_t down,
    input  lgrs_pkg::row_t mask,
    output lgrs_pkg::row_t next
);

    logic [lgrs_pkg::ROW_WIDTH+1:0] up_pad;
    logic [lgrs_pkg::ROW_WIDTH+1:0] mid_pad;
    logic [lgrs_pkg::ROW_WIDTH+1:0] down_pad;
    lgrs_pkg::row_t                 lane_alive;

    // Masked rows with a dead column on each side of the grid.
    assign up_pad   = {1'b0, up & mask, 1'b0};
    assign mid_pad  = {1'b0, mid & mask, 1'b0};
    assign down_pad = {1'b0, down & mask, 1'b0};

    // One lane per column sees a three by three window.
    for (genvar c = 0; c < lgrs_pkg::ROW_WIDTH; c++)
    begin : g_lane
        lgrs_lane u_lane
        (
            .up    (up_pad[c+2:c]),
            .mid   (mid_pad[c+2:c]),
            .down  (down_pad[c+2:c]),
            .alive (lane_alive[c])
        );
    end

    // Merge: columns at or beyond the width are always dead.
    assign next = lane_alive & mask;

endmodule

// ===== rtl/lgrs_queue.sv =====
// ============================================================================
// lgrs_queue: result queue
// Small register queue that takes up to two results per cycle and hands
// one result per transaction to the output channel.
// ============================================================================
module lgrs_queue
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lgrs_pkg::queue_push_t                 push,
    input  logic                                  pop,
    output lgrs_pkg::result_t                     head,
    output logic [lgrs_pkg::QUEUE_CNT_W-1:0]      count
);

    lgrs_pkg::result_t                  entry_reg [lgrs_pkg::QUEUE_DEPTH];
    logic [lgrs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [lgrs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [lgrs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [lgrs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [lgrs_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [lgrs_pkg::QUEUE_CNT_W-1:0]   count_next;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + lgrs_pkg::QUEUE_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + lgrs_pkg::QUEUE_PTR_W'(pop);
        count_next  = count_reg + lgrs_pkg::QUEUE_CNT_W'(push.count)
                    - lgrs_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; the second result goes to the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + lgrs_pkg::QUEUE_PTR_W'(1)] <= push.second;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== rtl/lgrs_checker.sv =====
// ============================================================================
// lgrs_checker: port-level checks for the row stepper
// Watches the channels of the top level over time; bound to it below.
// ============================================================================
module lgrs_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             last_row,
    input logic                             out_valid,
    input logic                             out_ready,
    input lgrs_pkg::row_t                   next_cells,
    input logic [lgrs_pkg::ROW_IDX_W-1:0]   out_row_index,
    input logic                             frame_done
);

    // A stalled result stays offered.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(next_cells) && $stable(out_row_index)
                                    && $stable(frame_done))
        else $error("result payload changed while stalled");

    // A bottom row always releases a result on the next cycle.
    a_last_row_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_row |=> out_valid)
        else $error("bottom row released no result");

    // Input is held off only while results are waiting.
    a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind life_generation_row_stepper lgrs_checker u_lgrs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .last_row      (in_ch.last_row),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .next_cells    (out_ch.next_cells),
    .out_row_index (out_ch.out_row_index),
    .frame_done    (out_ch.frame_done)
);
